>>> src/gsr_pkg.sv
package gsr_pkg;

    // Fixed-point constants
    localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
    localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [31:0] SAT_Q16   = 32'hFFFF_FFFF;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DOMAIN = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    // Handshake between the queue and its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> src/gsr_queue.sv
module gsr_queue #(
    parameter int W = 118
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [W-1:0]           wdata,
    input  logic                   pop,
    output logic [W-1:0]           rdata,
    output gsr_pkg::q_status_t     status
);

    logic [W-1:0] mem [2];
    logic         wp_reg, wp_next;
    logic         rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         do_push, do_pop;

    assign status.full  = (cnt_reg == 2'd2);
    assign status.empty = (cnt_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem[rp_reg];

    // Pointer and fill count update
    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wp_reg] <= wdata;
        end
    end

endmodule

>>> src/gsr_front.sv
module gsr_front #(
    parameter int MAX_LEN = 65536
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            sample,
    input  logic                   last_of_vector,
    output logic                   push,
    output logic [1+$clog2(MAX_LEN+1)*3+66-1:0] job,
    input  gsr_pkg::q_status_t     q_status
);

    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int LSW = CW + 23;
    localparam int SQW = CW + 43;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_LOG  = 3'd1;
    localparam logic [2:0] F_MUL  = 3'd2;
    localparam logic [2:0] F_ACC  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic signed [LSW-1:0] lsum_reg, lsum_next;
    logic [SQW-1:0]        sqsum_reg, sqsum_next;
    logic                  err_reg, err_next;
    logic                  last_reg, last_next;
    logic [31:0]           m_reg, m_next;
    logic [23:0]           frac_reg, frac_next;
    logic [4:0]            p_reg, p_next;
    logic [4:0]            it_reg, it_next;
    logic [20:0]           lmag_reg, lmag_next;
    logic                  lneg_reg, lneg_next;

    logic [4:0]            p_hi;
    logic [63:0]           msq;
    logic [32:0]           ms;
    logic signed [29:0]    l2;
    logic [28:0]           l2mag;
    logic [60:0]           lprod;
    logic [41:0]           lsq;

    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH);
    assign job      = {err_reg, cnt_reg, lsum_reg, sqsum_reg};

    // Leading one of the sample
    always_comb
    begin
        p_hi = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (sample[i])
            begin
                p_hi = 5'(i);
            end
        end
    end

    // Datapath pieces
    assign msq   = 64'(m_reg) * 64'(m_reg);
    assign ms    = msq[63:31];
    assign l2    = {6'(signed'({1'b0, p_reg}) - 6'sd16), frac_reg};
    assign l2mag = l2[29] ? 29'(-l2) : 29'(l2);
    assign lprod = 61'(l2mag) * 61'(gsr_pkg::LN2_Q32);
    assign lsq   = 42'(lmag_reg) * 42'(lmag_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lsum_next  = lsum_reg;
        sqsum_next = sqsum_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        p_next     = p_reg;
        it_next    = it_reg;
        lmag_next  = lmag_reg;
        lneg_next  = lneg_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = last_of_vector;
                    if (cnt_reg < CW'(MAX_LEN) && sample != 32'd0)
                    begin
                        p_next     = p_hi;
                        m_next     = sample << (5'd31 - p_hi);
                        frac_next  = 24'd0;
                        it_next    = 5'd0;
                        state_next = F_LOG;
                    end
                    else
                    begin
                        if (cnt_reg < CW'(MAX_LEN))
                        begin
                            err_next = 1'b1;
                        end
                        state_next = last_of_vector ? F_PUSH : F_IDLE;
                    end
                end
            end
            // One squaring round of the log2 mantissa per cycle
            F_LOG:
            begin
                frac_next = {frac_reg[22:0], ms[32]};
                m_next    = ms[32] ? ms[32:1] : ms[31:0];
                it_next   = it_reg + 5'd1;
                if (it_reg == 5'd23)
                begin
                    state_next = F_MUL;
                end
            end
            // log2 to ln, rounded to Q.16
            F_MUL:
            begin
                lmag_next  = 21'((lprod + 61'(64'h80_0000_0000)) >> 40);
                lneg_next  = l2[29];
                state_next = F_ACC;
            end
            F_ACC:
            begin
                lsum_next  = lneg_reg ? lsum_reg - LSW'(lmag_reg) : lsum_reg + LSW'(lmag_reg);
                sqsum_next = sqsum_reg + SQW'(lsq);
                cnt_next   = cnt_reg + CW'(1);
                state_next = last_reg ? F_PUSH : F_IDLE;
            end
            // Hand the finished sums to the back end, then clear
            F_PUSH:
            begin
                if (!q_status.full)
                begin
                    cnt_next   = '0;
                    lsum_next  = '0;
                    sqsum_next = '0;
                    err_next   = 1'b0;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            lsum_reg  <= '0;
            sqsum_reg <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lsum_reg  <= lsum_next;
            sqsum_reg <= sqsum_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        p_reg    <= p_next;
        it_reg   <= it_next;
        lmag_reg <= lmag_next;
        lneg_reg <= lneg_next;
    end

endmodule

>>> src/gsr_back.sv
module gsr_back #(
    parameter int MAX_LEN = 65536
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1+$clog2(MAX_LEN+1)*3+66-1:0] job,
    input  gsr_pkg::q_status_t     q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            geo_std,
    output logic [1:0]             status
);

    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int LSW = CW + 23;
    localparam int SQW = CW + 43;
    localparam int DW  = 2 * LSW;
    localparam int RW  = 2 * CW;
    localparam int ITW = $clog2(DW + 1);

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_MUL   = 4'd1;
    localparam logic [3:0] B_SUB   = 4'd2;
    localparam logic [3:0] B_DIV   = 4'd3;
    localparam logic [3:0] B_SQRT  = 4'd4;
    localparam logic [3:0] B_T     = 4'd5;
    localparam logic [3:0] B_Y     = 4'd6;
    localparam logic [3:0] B_TERM  = 4'd7;
    localparam logic [3:0] B_KDIV  = 4'd8;
    localparam logic [3:0] B_ROUND = 4'd9;
    localparam logic [3:0] B_OUT   = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic [ITW-1:0]        it_reg, it_next;
    logic [CW-1:0]         mca_reg, mca_next;
    logic [LSW-1:0]        mcb_reg, mcb_next;
    logic [DW-1:0]         mda_reg, mda_next;
    logic [DW-1:0]         mdb_reg, mdb_next;
    logic [DW-1:0]         pa_reg, pa_next;
    logic [DW-1:0]         pb_reg, pb_next;
    logic [RW-1:0]         den_reg, den_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [47:0]           var_reg, var_next;
    logic                  ovf_reg, ovf_next;
    logic [63:0]           v_reg, v_next;
    logic [63:0]           r_reg, r_next;
    logic [63:0]           bit_reg, bit_next;
    logic [33:0]           t_reg, t_next;
    logic [31:0]           y_reg, y_next;
    logic [32:0]           term_reg, term_next;
    logic [33:0]           sum_reg, sum_next;
    logic [32:0]           num_reg, num_next;
    logic [3:0]            krem_reg, krem_next;
    logic [3:0]            k_reg, k_next;
    logic [31:0]           geo_reg, geo_next;
    logic [1:0]            st_reg, st_next;

    logic                  j_err;
    logic [CW-1:0]         j_cnt;
    logic signed [LSW-1:0] j_lsum;
    logic [SQW-1:0]        j_sqsum;
    logic [LSW-1:0]        s1mag;
    logic [RW:0]           remsh;
    logic                  qbit;
    logic [46:0]           vcap;
    logic [63:0]           rb;
    logic [65:0]           tprod;
    logic [55:0]           yprod;
    logic [64:0]           typrod;
    logic [4:0]            kremsh;
    logic                  kbit;
    logic [3:0]            ip4;
    logic [34:0]           rnd;
    logic [34:0]           res;

    assign {j_err, j_cnt, j_lsum, j_sqsum} = job;
    assign s1mag = j_lsum[LSW-1] ? LSW'(-j_lsum) : LSW'(j_lsum);

    assign pop       = (state_reg == B_IDLE) && !q_status.empty;
    assign out_valid = (state_reg == B_OUT);
    assign geo_std   = geo_reg;
    assign status    = st_reg;

    // Long division step
    assign remsh = {rem_reg, pa_reg[DW-1]};
    assign qbit  = (remsh >= {1'b0, den_reg});
    assign vcap  = (ovf_reg || var_reg[47] || var_reg[46]) ? {47{1'b1}}
                                                           : {var_reg[45:0], qbit};

    // Other datapath pieces
    assign rb     = r_reg + bit_reg;
    assign tprod  = 66'(r_reg[32:0]) * 66'(gsr_pkg::LOG2E_Q32);
    assign yprod  = 56'(t_reg[23:0]) * 56'(gsr_pkg::LN2_Q32);
    assign typrod = 65'(term_reg) * 65'(y_reg);
    assign kremsh = {krem_reg, num_reg[32]};
    assign kbit   = (kremsh >= {1'b0, k_reg});
    assign ip4    = t_reg[27:24];
    assign rnd    = 35'(sum_reg) + (35'd1 << (4'd15 - ip4));
    assign res    = rnd >> (5'd16 - {1'b0, ip4});

    always_comb
    begin
        state_next = state_reg;
        it_next    = it_reg;
        mca_next   = mca_reg;
        mcb_next   = mcb_reg;
        mda_next   = mda_reg;
        mdb_next   = mdb_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        var_next   = var_reg;
        ovf_next   = ovf_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        t_next     = t_reg;
        y_next     = y_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        num_next   = num_reg;
        krem_next  = krem_reg;
        k_next     = k_reg;
        geo_next   = geo_reg;
        st_next    = st_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    mca_next   = j_cnt;
                    mcb_next   = s1mag;
                    mda_next   = DW'(j_sqsum);
                    mdb_next   = DW'(s1mag);
                    pa_next    = '0;
                    pb_next    = '0;
                    den_next   = RW'(j_cnt) * RW'(j_cnt);
                    it_next    = '0;
                    if (j_err)
                    begin
                        geo_next   = 32'd0;
                        st_next    = gsr_pkg::ST_DOMAIN;
                        state_next = B_OUT;
                    end
                    else if (j_cnt == '0)
                    begin
                        geo_next   = gsr_pkg::ONE_Q16;
                        st_next    = gsr_pkg::ST_OK;
                        state_next = B_OUT;
                    end
                    else
                    begin
                        state_next = B_MUL;
                    end
                end
            end
            // Shift-add products n*S2 and S1*S1, one multiplier bit per cycle
            B_MUL:
            begin
                if (mca_reg[0])
                begin
                    pa_next = pa_reg + mda_reg;
                end
                if (mcb_reg[0])
                begin
                    pb_next = pb_reg + mdb_reg;
                end
                mca_next = mca_reg >> 1;
                mcb_next = mcb_reg >> 1;
                mda_next = mda_reg << 1;
                mdb_next = mdb_reg << 1;
                it_next  = it_reg + ITW'(1);
                if (it_reg == ITW'(LSW - 1))
                begin
                    state_next = B_SUB;
                end
            end
            B_SUB:
            begin
                pa_next    = pa_reg - pb_reg;
                rem_next   = '0;
                var_next   = '0;
                ovf_next   = 1'b0;
                it_next    = '0;
                state_next = B_DIV;
            end
            // Restoring division by n*n, one quotient bit per cycle
            B_DIV:
            begin
                rem_next = qbit ? RW'(remsh - {1'b0, den_reg}) : RW'(remsh);
                pa_next  = pa_reg << 1;
                ovf_next = ovf_reg | var_reg[47];
                var_next = {var_reg[46:0], qbit};
                it_next  = it_reg + ITW'(1);
                if (it_reg == ITW'(DW - 1))
                begin
                    v_next     = {1'b0, vcap, 16'd0};
                    r_next     = '0;
                    bit_next   = 64'h4000_0000_0000_0000;
                    state_next = B_SQRT;
                end
            end
            // Bitwise square root, two radicand bits per cycle
            B_SQRT:
            begin
                if (v_reg >= rb)
                begin
                    v_next = v_reg - rb;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 64'd1)
                begin
                    state_next = B_T;
                end
            end
            B_T:
            begin
                t_next     = 34'((tprod + 66'h8000_0000) >> 32);
                state_next = B_Y;
            end
            B_Y:
            begin
                if (t_reg[33:28] != 6'd0)
                begin
                    geo_next   = gsr_pkg::SAT_Q16;
                    st_next    = gsr_pkg::ST_SAT;
                    state_next = B_OUT;
                end
                else
                begin
                    y_next     = yprod[55:24];
                    term_next  = 33'h1_0000_0000;
                    sum_next   = 34'h1_0000_0000;
                    k_next     = 4'd1;
                    state_next = B_TERM;
                end
            end
            B_TERM:
            begin
                num_next   = typrod[64:32];
                krem_next  = 4'd0;
                it_next    = '0;
                state_next = B_KDIV;
            end
            // Term divided by k, one quotient bit per cycle
            B_KDIV:
            begin
                krem_next = kbit ? 4'(kremsh - {1'b0, k_reg}) : kremsh[3:0];
                num_next  = {num_reg[31:0], kbit};
                it_next   = it_reg + ITW'(1);
                if (it_reg == ITW'(32))
                begin
                    term_next  = {num_reg[31:0], kbit};
                    sum_next   = sum_reg + 34'({num_reg[31:0], kbit});
                    k_next     = k_reg + 4'd1;
                    state_next = (k_reg == 4'd14) ? B_ROUND : B_TERM;
                end
            end
            B_ROUND:
            begin
                if (res[34:32] != 3'd0)
                begin
                    geo_next = gsr_pkg::SAT_Q16;
                    st_next  = gsr_pkg::ST_SAT;
                end
                else
                begin
                    geo_next = res[31:0];
                    st_next  = gsr_pkg::ST_OK;
                end
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg   <= it_next;
        mca_reg  <= mca_next;
        mcb_reg  <= mcb_next;
        mda_reg  <= mda_next;
        mdb_reg  <= mdb_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        var_reg  <= var_next;
        ovf_reg  <= ovf_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        t_reg    <= t_next;
        y_reg    <= y_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        num_reg  <= num_next;
        krem_reg <= krem_next;
        k_reg    <= k_next;
        geo_reg  <= geo_next;
        st_reg   <= st_next;
    end

endmodule

>>> src/geometric_std_reduction_unit.sv
// Geometric standard deviation of a stream of vectors.
// Input stream: one unsigned Q16.16 sample per transfer in s_axis_tdata, with
// s_axis_tlast on the final sample of a vector. Output stream: one transfer per
// vector, the result in m_axis_tdata (Q16.16; 0 after a zero sample, else at
// least 1.0) and the status in m_axis_tuser (ok, zero sample seen, saturated).
// Front end: each sample is accepted, then passes a log unit that runs
// 24 squaring rounds on one 32x32 multiplier, then scale and sum; no new
// sample is taken before that one is summed. A zero sample or one past MAX_LEN
// is not summed. The marked sample then hands its sums to a two-entry queue.
// Back end: per vector, the serial multiplies, the 80-bit long division,
// the square root and 14 Taylor terms, each one bit or step per cycle.
// The front end keeps taking samples of the next vector while the back end
// works, until it has sums to hand over and the queue is full.
// Reset clears the sums, the queue and both controllers; no clearing pass.
// When the receiver stalls, the result holds in its output register, the back
// end waits, and the front end stalls on its next hand-over to a full queue.
module geometric_std_reduction_unit #(
    parameter int MAX_LEN = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] geo_std
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int JW = 1 + 3 * CW + 66;

    logic               push;
    logic               pop;
    logic [JW-1:0]      job_in;
    logic [JW-1:0]      job_out;
    gsr_pkg::q_status_t q_status;

    // Sample intake, log and accumulate
    gsr_front #(
        .MAX_LEN(MAX_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .sample        (s_axis_tdata),
        .last_of_vector(s_axis_tlast),
        .push          (push),
        .job           (job_in),
        .q_status      (q_status)
    );

    // Finished sums waiting for the back end
    gsr_queue #(
        .W(JW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .pop   (pop),
        .rdata (job_out),
        .status(q_status)
    );

    // Variance, square root and exponential
    gsr_back #(
        .MAX_LEN(MAX_LEN)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job_out),
        .q_status (q_status),
        .pop      (pop),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .geo_std  (m_axis_tdata),
        .status   (m_axis_tuser)
    );

endmodule

>>> test/gsr_checker.sv
// Watches both streams of the reduction unit, predicts each vector result
// from the accepted samples and compares it with what leaves the block.
module gsr_checker #(
    parameter int MAX_LEN = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    output int          mismatches,
    output int          pending,
    output int          results_checked
);

    typedef struct packed {
        logic [31:0] geo_std;
        logic [1:0]  status;
    } gsd_result_t;

    gsd_result_t result_fifo[$];

    // Running state of the vector in progress
    logic [31:0]        n_samples;
    longint             ln_sum;
    logic [63:0]        ln_sq_sum;
    logic               saw_zero;

    // Natural log of a Q16.16 value, result in Q.16
    function automatic longint ln_q16(input logic [31:0] x);
        int          p;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] mag;
        logic [63:0] r;
        longint      l2;
        p = 31;
        while (p > 0 && x[p] == 1'b0) p--;
        m = {32'b0, x} << (31 - p);
        frac = 64'd0;
        for (int i = 0; i < 24; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        l2 = (longint'(p) - 16) * 64'sd16777216 + longint'(frac);
        mag = (l2 < 0) ? 64'(-l2) : 64'(l2);
        r = (mag * {32'b0, gsr_pkg::LN2_Q32} + (64'd1 << 39)) >> 40;
        return (l2 < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 64'd0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // exp(sqrt(variance of logs)) from the running sums
    function automatic gsd_result_t geo_std_of(input logic [31:0] n32, input longint s1,
                                               input logic [63:0] s2);
        gsd_result_t  res;
        logic [127:0] n_s2;
        logic [127:0] s1_sq;
        logic [127:0] quo;
        logic [63:0]  n;
        logic [63:0]  s1mag;
        logic [63:0]  var_q32;
        logic [63:0]  sd;
        logic [63:0]  t;
        logic [63:0]  ip;
        logic [63:0]  y;
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [63:0]  rounded;
        n = {32'b0, n32};
        res.geo_std = gsr_pkg::ONE_Q16;
        res.status  = gsr_pkg::ST_OK;
        if (n == 64'd0) return res;
        s1mag = (s1 < 0) ? 64'(-s1) : 64'(s1);
        n_s2  = {64'b0, n} * {64'b0, s2};
        s1_sq = {64'b0, s1mag} * {64'b0, s1mag};
        quo   = (n_s2 - s1_sq) / {64'b0, n * n};
        if (quo >= (128'd1 << 47))
            var_q32 = (64'd1 << 47) - 64'd1;
        else
            var_q32 = quo[63:0];
        sd = int_sqrt(var_q32 << 16);
        t  = (sd * {31'b0, gsr_pkg::LOG2E_Q32} + (64'd1 << 31)) >> 32;
        ip = t >> 24;
        if (ip >= 64'd16)
        begin
            res.geo_std = gsr_pkg::SAT_Q16;
            res.status  = gsr_pkg::ST_SAT;
            return res;
        end
        y = ((t & 64'hFF_FFFF) * {32'b0, gsr_pkg::LN2_Q32}) >> 24;
        sum  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 14; k++)
        begin
            term = ((term * y) >> 32) / 64'(k);
            sum  = sum + term;
        end
        rounded = (sum + (64'd1 << (15 - ip))) >> (16 - ip);
        if (rounded > 64'hFFFF_FFFF)
        begin
            res.geo_std = gsr_pkg::SAT_Q16;
            res.status  = gsr_pkg::ST_SAT;
        end
        else
            res.geo_std = rounded[31:0];
        return res;
    endfunction

    assign pending = result_fifo.size();

    // Accumulate samples, queue a prediction on each marked sample
    always @(posedge clk or negedge rst_n)
    begin
        gsd_result_t lv;
        longint      l;
        logic [63:0] mag;
        if (!rst_n)
        begin
            n_samples = 32'd0;
            ln_sum    = 0;
            ln_sq_sum = 64'd0;
            saw_zero  = 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            if (n_samples < MAX_LEN)
            begin
                if (s_axis_tdata == 32'd0)
                    saw_zero = 1'b1;
                else
                begin
                    l = ln_q16(s_axis_tdata);
                    mag = (l < 0) ? 64'(-l) : 64'(l);
                    ln_sum    = ln_sum + l;
                    ln_sq_sum = ln_sq_sum + mag * mag;
                    n_samples = n_samples + 1;
                end
            end
            if (s_axis_tlast)
            begin
                if (saw_zero)
                begin
                    lv.geo_std = 32'd0;
                    lv.status  = gsr_pkg::ST_DOMAIN;
                end
                else
                    lv = geo_std_of(n_samples, ln_sum, ln_sq_sum);
                result_fifo.push_back(lv);
                n_samples = 32'd0;
                ln_sum    = 0;
                ln_sq_sum = 64'd0;
                saw_zero  = 1'b0;
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        gsd_result_t want;
        if (!rst_n)
        begin
            mismatches      = 0;
            results_checked = 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (result_fifo.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: geo_std=%h status=%0d",
                             m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = result_fifo.pop_front();
                if (m_axis_tdata !== want.geo_std || m_axis_tuser !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected geo_std=%h status=%0d, got %h %0d",
                                 results_checked, want.geo_std, want.status,
                                 m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

endmodule

>>> test/tb_geometric_std_reduction_unit.sv
module tb_geometric_std_reduction_unit;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 3000;
    localparam int RANDOM_ITEMS   = 930;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int  mismatches;
    int  pending;
    int  results_checked;
    int  samples_sent = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;

    always #5 clk = ~clk;

    geometric_std_reduction_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    gsr_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // One sample transfer, with an optional idle burst ahead of it
    task automatic push_sample(input logic [31:0] value, input logic mark);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= mark;
        @(negedge clk);
        while (!s_axis_tready) @(negedge clk);
        @(posedge clk);
        samples_sent++;
    endtask

    // Sample values biased toward ones whose logs spread in useful ways
    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1, 2:    return 32'h0001_0000 + $urandom_range(0, 4096) - 2048;
            3:       return $urandom_range(1, 255);
            4:       return 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                n = 0;
                while (n < LONG_HOLD)
                begin
                    @(posedge clk);
                    n++;
                end
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("tb_geometric_std_reduction_unit: FAIL");
            $finish;
        end
    end

    initial
    begin
        int len;
        int sent_rand;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed vectors: extremes, unit value, zero samples, wide spread
        push_sample(32'h0000_0001, 1'b1);
        push_sample(32'hFFFF_FFFF, 1'b1);
        push_sample(32'h0001_0000, 1'b1);
        push_sample(32'h0000_0000, 1'b1);
        push_sample(32'h0001_0000, 1'b0);
        push_sample(32'h0002_0000, 1'b1);
        push_sample(32'h0000_0001, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b1);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'h0000_0001, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'h0000_0001, 1'b1);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'h0000_0005, 1'b1);
        push_sample(32'h0003_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b1);
        push_sample(32'h0000_8000, 1'b0);
        push_sample(32'h0002_0000, 1'b0);
        push_sample(32'h0001_0000, 1'b1);
        push_sample(32'h0001_0000, 1'b0);
        push_sample(32'h0001_0000, 1'b1);

        // Random vectors of mostly short length
        sent_rand = 0;
        while (sent_rand < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                push_sample(pick_sample(), i == len - 1);
                sent_rand++;
                if (sent_rand == 300)
                    hold_req = 1'b1;
                if (sent_rand == RANDOM_ITEMS - 120)
                    calm = 1'b1;
            end
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        // Drain, then allow the back end time for any stray output
        while (pending != 0) @(posedge clk);
        repeat (1500) @(posedge clk);

        $display("sent %0d samples in vectors of 1 to 40, checked %0d results,",
                 samples_sent, results_checked);
        $display("including zero samples, saturation, and a long output stall");
        if (mismatches == 0 && pending == 0)
            $display("tb_geometric_std_reduction_unit: PASS");
        else
            $display("tb_geometric_std_reduction_unit: FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/gsr_pkg.sv
src/gsr_queue.sv
src/gsr_front.sv
src/gsr_back.sv
src/geometric_std_reduction_unit.sv
test/gsr_checker.sv
test/tb_geometric_std_reduction_unit.sv
